/* hdl/scrc_pkg.sv */
// Package: payload types and character constants for the cell reference converter.
`timescale 1ns / 1ps
package scrc_pkg;
	localparam int MAX_CHARS_DEF   = 16;
	localparam int MAX_LETTERS_DEF = 5;
	localparam int OUT_MAX         = 16;
	localparam logic [23:0] NUM_LIMIT = 24'hFFFFFF;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_Z = 8'h5A;
	localparam logic [7:0] CH_C = 8'h43;
	localparam logic [7:0] CH_R = 8'h52;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] ch_res;
		logic       last_res;
		logic       error;
	} out_word_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction
endpackage

/* hdl/spreadsheet_cell_ref_convert_top.sv */
// Top level: cell reference converter between A1 and R1C1 notation.
//
// Usage: characters of one reference arrive on the in channel (valid/ready),
// one word per character, last high on the final one. Words with last low
// give no output. After the last word the block scans its character memory
// one entry per cycle in a single pass, reads the digits back, builds the
// converted text in an output memory, then emits it one word at a time on
// the out channel with last_res on the final word. Invalid references give
// one word with ch_res 0, last_res 1, error 1.
// Throughput: one input word per cycle while loading. After the last word the
// block scans the N characters, reads the numbers back digit by digit, makes
// each converted character by reciprocal divide, remainder and store, and then
// emits the L output words, which out-channel stalls can hold up.
// Input is held off (ready low) during conversion and emission. A stall on
// the out channel holds the current word; the output register sits apart
// from the memory read so emission resumes without loss.
// Reset clears the control state; memory contents need no clearing.
`timescale 1ns / 1ps
module spreadsheet_cell_ref_convert_top #(
	parameter int MAX_CHARS   = scrc_pkg::MAX_CHARS_DEF,
	parameter int MAX_LETTERS = scrc_pkg::MAX_LETTERS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  scrc_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output scrc_pkg::out_word_t out_data
);
	import scrc_pkg::*;

	localparam int AW = $clog2(MAX_CHARS);
	localparam int LW = $clog2(MAX_CHARS + 1);
	localparam int OW = $clog2(OUT_MAX);
	// ceil(2^30/26) and ceil(2^29/10): exact quotients for dividends below 2^25
	localparam logic [25:0] RECIP_26 = 26'd41297763;
	localparam logic [25:0] RECIP_10 = 26'd53687092;

	typedef enum logic [4:0] {
		S_LOAD, S_SCAN, S_ROWRD, S_ROWWT, S_ROW, S_COLRD, S_COLWT, S_COL, S_LET,
		S_CHK, S_DIVI, S_DIV, S_PUTD, S_EMITI, S_EMITR, S_EMITW, S_ERR
	} state_t;

	// which number is being written
	typedef enum logic [1:0] {
		P_LET, P_ROW, P_COL, P_RCROW
	} phase_t;

	logic [7:0] cmem [MAX_CHARS];
	logic [7:0] omem [OUT_MAX];

	state_t      st_q;
	logic [LW-1:0] len_q;
	logic        ovf_q;
	logic [LW-1:0] pos_q;
	logic [7:0]  prev_q;
	logic        rc_q;
	logic        cfound_q;
	logic [LW-1:0] cpos_q;
	logic        nfound_q;
	logic [LW-1:0] npos_q;
	logic        bad_let_q;
	logic [24:0] row_q, col_q;
	logic        first_q;
	// digit stack for number output
	logic [7:0]  tmp_q [8];
	logic [3:0]  tk_q;
	logic [24:0] dv_q;   // dividend
	logic [24:0] quo_q;
	logic        radix_q; // 1: letters (26), 0: decimal
	phase_t      phase_q;
	logic [4:0]  olen_q;
	logic [OW-1:0] oi_q;
	logic        val_q;
	out_word_t   od_q;

	logic [AW-1:0] raddr;
	logic [7:0]    rdata;
	logic [4:0]    divisor;
	logic [50:0]   prod_w;
	logic [24:0]   quo_w;
	logic [4:0]    rem_w;
	logic [29:0]   col_ext;

	assign in_ready = (st_q == S_LOAD);
	assign out_valid = val_q;
	assign out_data = od_q;
	assign raddr = pos_q[AW-1:0];
	assign divisor = radix_q ? 5'd26 : 5'd10;
	assign prod_w = 51'(dv_q) * 51'(radix_q ? RECIP_26 : RECIP_10);
	assign quo_w = radix_q ? 25'(prod_w[50:30]) : 25'(prod_w[50:29]);
	assign rem_w = 5'(dv_q - quo_q * 25'(divisor));
	assign col_ext = 30'(col_q) * 30'd26 + 30'(rdata - CH_A) + 30'd1;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready && (len_q < LW'(MAX_CHARS)))
			cmem[len_q[AW-1:0]] <= in_data.ch;
		rdata <= cmem[raddr];
	end

	logic [7:0] om_rd;
	always_ff @(posedge clk) begin
		if (st_q == S_PUTD && tk_q != 4'd0 && olen_q < 5'(OUT_MAX))
			omem[olen_q[OW-1:0]] <= tmp_q[tk_q[2:0] - 3'd1];
		else if (st_q == S_CHK && !rc_q)
			omem[0] <= CH_R;
		else if (st_q == S_DIVI && phase_q == P_COL)
			omem[olen_q[OW-1:0]] <= CH_C;
		om_rd <= omem[oi_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_LOAD; len_q <= '0; ovf_q <= 1'b0; val_q <= 1'b0;
			pos_q <= '0; olen_q <= '0; oi_q <= '0; tk_q <= '0; phase_q <= P_LET;
			rc_q <= 1'b0; cfound_q <= 1'b0; nfound_q <= 1'b0; bad_let_q <= 1'b0;
			first_q <= 1'b0; radix_q <= 1'b0;
		end else begin
			// emitting states reload the word themselves
			if (val_q && out_ready && st_q != S_EMITR && st_q != S_ERR) val_q <= 1'b0;
			case (st_q)
				S_LOAD: if (in_valid) begin
					if (len_q < LW'(MAX_CHARS)) len_q <= len_q + 1'b1;
					else ovf_q <= 1'b1;
					if (in_data.last) begin
						if (ovf_q || len_q >= LW'(MAX_CHARS)) st_q <= S_ERR;
						else begin
							st_q <= S_SCAN; pos_q <= '0; first_q <= 1'b1;
							rc_q <= 1'b0; cfound_q <= 1'b0; nfound_q <= 1'b0;
							bad_let_q <= 1'b0; col_q <= '0;
						end
					end
				end
				// one pass: rc-form test, first 'C', first char <= '9', letter column
				S_SCAN: begin
					if (!first_q) begin
						prev_q <= rdata;
						if (pos_q > 1 && is_digit(prev_q) && rdata > CH_9) rc_q <= 1'b1;
						if (!cfound_q && rdata == CH_C) begin
							cfound_q <= 1'b1; cpos_q <= pos_q - 1'b1;
						end
						if (!nfound_q) begin
							if (rdata <= CH_9) begin
								nfound_q <= 1'b1; npos_q <= pos_q - 1'b1;
							end else if (rdata < CH_A || rdata > CH_Z
									|| pos_q > LW'(MAX_LETTERS))
								bad_let_q <= 1'b1;
							else if (!col_q[24])
								col_q <= (col_ext > 30'(NUM_LIMIT)) ? 25'h1000000 : col_ext[24:0];
						end
					end
					first_q <= 1'b0;
					if (pos_q == len_q) st_q <= S_CHK;
					else pos_q <= pos_q + 1'b1;
				end
				S_CHK: begin
					row_q <= '0;
					if (rc_q) begin
						if (!cfound_q || cpos_q == 0) st_q <= S_ERR;
						else begin pos_q <= LW'(1); st_q <= S_ROWRD; end
					end else begin
						if (!nfound_q || npos_q == 0 || npos_q > LW'(MAX_LETTERS)
								|| bad_let_q || col_q > {1'b0, NUM_LIMIT})
							st_q <= S_ERR;
						else begin pos_q <= npos_q; olen_q <= 5'd1; st_q <= S_ROWRD; end
					end
				end
				S_ROWRD: begin first_q <= 1'b1; st_q <= S_ROWWT; end
				S_ROWWT: st_q <= S_ROW;
				S_ROW: begin
					if (pos_q < len_q && is_digit(rdata)) begin
						if (row_q > 25'd1677721 ||
								25'(row_q * 25'd10) + 25'(rdata - CH_0) > {1'b0, NUM_LIMIT})
							st_q <= S_ERR;
						else begin
							row_q <= 25'(row_q * 25'd10) + 25'(rdata - CH_0);
							pos_q <= pos_q + 1'b1; first_q <= 1'b0; st_q <= S_ROWWT;
						end
					end else if (first_q) st_q <= S_ERR;
					else if (rc_q) begin
						pos_q <= cpos_q + 1'b1; col_q <= '0; st_q <= S_COLRD;
					end else begin phase_q <= P_ROW; radix_q <= 1'b0; dv_q <= row_q;
						st_q <= S_DIVI; end
				end
				S_COLRD: begin first_q <= 1'b1; st_q <= S_COLWT; end
				S_COLWT: st_q <= S_COL;
				S_COL: begin
					if (pos_q < len_q && is_digit(rdata)) begin
						if (col_q > 25'd1677721 ||
								25'(col_q * 25'd10) + 25'(rdata - CH_0) > {1'b0, NUM_LIMIT})
							st_q <= S_ERR;
						else begin
							col_q <= 25'(col_q * 25'd10) + 25'(rdata - CH_0);
							pos_q <= pos_q + 1'b1; first_q <= 1'b0; st_q <= S_COLWT;
						end
					end else if (first_q || col_q == 0) st_q <= S_ERR;
					else begin
						olen_q <= '0; phase_q <= P_LET; radix_q <= 1'b1; dv_q <= col_q;
						st_q <= S_DIVI;
					end
				end
				// start one number: clear the digit stack
				S_DIVI: begin
					tk_q <= '0;
					if (phase_q == P_COL) olen_q <= olen_q + 1'b1;
					if (radix_q && dv_q == 0) st_q <= S_PUTD;
					else st_q <= S_DIV;
				end
				// quotient by reciprocal multiply; remainder follows from it
				S_DIV: begin
					quo_q <= quo_w;
					st_q <= S_LET;
				end
				S_LET: begin
					tk_q <= tk_q + 1'b1;
					if (radix_q) begin
						if (rem_w == 5'd0) begin
							tmp_q[tk_q[2:0]] <= CH_Z; dv_q <= quo_q - 1'b1;
							st_q <= (quo_q == 25'd1 || tk_q == 4'd7) ? S_PUTD : S_DIV;
						end else begin
							tmp_q[tk_q[2:0]] <= CH_A + 8'(rem_w) - 8'd1; dv_q <= quo_q;
							st_q <= (quo_q == 0 || tk_q == 4'd7) ? S_PUTD : S_DIV;
						end
					end else begin
						tmp_q[tk_q[2:0]] <= CH_0 + 8'(rem_w); dv_q <= quo_q;
						st_q <= (quo_q == 0) ? S_PUTD : S_DIV;
					end
				end
				// pop the stack into the output memory
				S_PUTD: begin
					if (tk_q == 0) begin
						case (phase_q)
							P_LET: begin phase_q <= P_RCROW; radix_q <= 1'b0; dv_q <= row_q;
								st_q <= S_DIVI; end
							P_ROW: begin phase_q <= P_COL; radix_q <= 1'b0; dv_q <= col_q;
								if (olen_q >= 5'd16) st_q <= S_ERR; else st_q <= S_DIVI; end
							default: begin oi_q <= '0; st_q <= S_EMITI; end
						endcase
					end else if (olen_q >= 5'd16) st_q <= S_ERR;
					else begin olen_q <= olen_q + 1'b1; tk_q <= tk_q - 1'b1; end
				end
				S_EMITI: st_q <= S_EMITR;
				S_EMITR: if (!val_q || out_ready) begin
					val_q <= 1'b1;
					od_q <= '{ch_res: om_rd, last_res: (5'(oi_q) + 5'd1 == olen_q), error: 1'b0};
					if (5'(oi_q) + 5'd1 == olen_q) st_q <= S_EMITW;
					else begin oi_q <= oi_q + 1'b1; st_q <= S_EMITI; end
				end
				S_EMITW: if (!val_q || out_ready) begin
					len_q <= '0; ovf_q <= 1'b0; st_q <= S_LOAD;
				end
				S_ERR: if (!val_q || out_ready) begin
					val_q <= 1'b1;
					od_q <= '{ch_res: 8'd0, last_res: 1'b1, error: 1'b1};
					st_q <= S_EMITW;
				end
				default: st_q <= S_LOAD;
			endcase
		end
	end
endmodule

/* hdl/scrc_checker.sv */
// Checker: port-level properties of the cell reference converter, bound to the top level.
`timescale 1ns / 1ps
module scrc_props (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input scrc_pkg::in_word_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input scrc_pkg::out_word_t out_data
);
	import scrc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.error |-> out_data.last_res && out_data.ch_res == 8'd0)
		else $error("error word malformed");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken during emission");
	a_nonlast_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_data.last |=> !out_valid)
		else $error("result after non-final word");
endmodule

bind spreadsheet_cell_ref_convert_top scrc_props u_scrc_props (.*);
